// ===== design/sparse_table_range_max_min_core_defines.svh =====
// Assertion macros used by the sparse-table range max/min core
`ifndef SPARSE_TABLE_RANGE_MAX_MIN_CORE_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MAX_MIN_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define STRMM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define STRMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/strmm_pkg.sv =====
// Constants, types and codes for the sparse-table range max/min core
package strmm_pkg;

  localparam int DEPTH  = 1024;
  localparam int LEVELS = 11;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int K_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int KC_W  = $clog2(LEVELS + 1);
  // wide enough for DEPTH up to 65536, spans up to 2^17 and index sums
  localparam int CMP_W = 18;
  localparam int LG_W  = $clog2(CMP_W);
  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] ELEM_RESET = 11'd1024;

  typedef logic signed [31:0] value_t;
  typedef logic [1:0]         op_t;
  typedef logic [1:0]         status_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_BUILD = 2'd1;
  localparam op_t OP_QUERY = 2'd2;

  localparam status_t ST_ANSWER    = 2'd0;
  localparam status_t ST_DONE      = 2'd1;
  localparam status_t ST_RANGE_ERR = 2'd2;

endpackage

// ===== design/sparse_table_range_max_min_core.sv =====
// Sparse-table range maximum / minimum engine: top level
//
// Commands are taken when start is high and busy is low. A load writes
// level 0 of both tables and gives no result; busy stays low.
// A query with a bad range (left > right, or right at or past the element
// count) gives status 2 in the cycle after it is taken, without raising busy.
// A good query holds busy through level select, two reads of the
// synchronous table port and compare, and its result strobes as busy drops.
// A build walks the levels with one shared read port and one compare per
// table: a check per level, then two reads and a write per entry built,
// then a done result. Each result is on out_* for one cycle with
// out_valid high; the receiver cannot stall it. Table entries never
// loaded or built read as unknown. element_count may be written at any
// time the core is idle.
`include "sparse_table_range_max_min_core_defines.svh"

module sparse_table_range_max_min_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  strmm_pkg::op_t     in_op,
  input  logic [9:0]         in_index_or_left,
  input  logic [9:0]         in_right_bound,
  input  strmm_pkg::value_t  in_first_value,
  input  strmm_pkg::value_t  in_second_value,
  input  logic               cfg_we,
  input  logic [10:0]        cfg_wdata,
  output logic               out_valid,
  output strmm_pkg::value_t  out_range_max,
  output strmm_pkg::value_t  out_range_min,
  output strmm_pkg::status_t out_status
);
  import strmm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QLOG = 4'd1;
  localparam logic [3:0] S_QRD0 = 4'd2;
  localparam logic [3:0] S_QRD1 = 4'd3;
  localparam logic [3:0] S_QOUT = 4'd4;
  localparam logic [3:0] S_BCHK = 4'd5;
  localparam logic [3:0] S_BRD0 = 4'd6;
  localparam logic [3:0] S_BRD1 = 4'd7;
  localparam logic [3:0] S_BWR  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] elem_r;
  logic [KC_W-1:0]  k_r, k_nxt;
  logic [CMP_W-1:0] j_r, j_nxt;
  logic [CMP_W-1:0] right_r, right_nxt;
  logic [CMP_W-1:0] a2_r, a2_nxt;
  value_t           rdmax_r, rdmin_r;
  value_t           amax_r, amin_r;
  logic             out_valid_r;
  value_t           out_max_r, out_min_r;
  status_t          out_status_r;

  value_t max_mem [LEVELS][DEPTH];
  value_t min_mem [LEVELS][DEPTH];

  logic             accept;
  logic             bad_range;
  logic [CMP_W-1:0] left_w, right_w, elem_w, n_act;
  logic [CMP_W-1:0] span, half, len;
  logic [LG_W-1:0]  lg;
  logic [KC_W-1:0]  lg_cap;
  logic             build_rd;
  logic [KC_W-1:0]  rd_lvl;
  logic [K_W-1:0]   rd_k, wr_k;
  logic [IDX_W-1:0] rd_j, wr_j;
  logic             wr_en;
  value_t           wr_max, wr_min;
  value_t           max_pick, min_pick;
  logic             emit;
  value_t           emit_max, emit_min;
  status_t          emit_status;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign left_w  = CMP_W'(in_index_or_left);
  assign right_w = CMP_W'(in_right_bound);
  assign elem_w  = CMP_W'(elem_r);
  assign n_act   = (elem_w > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : elem_w;

  assign bad_range = (left_w > right_w) || (right_w >= n_act);

  assign span = CMP_W'(1) << k_r;
  assign half = span >> 1;
  assign len  = right_r - j_r + CMP_W'(1);

  // floor log2 of the range length
  always_comb begin
    lg = '0;
    for (int b = 0; b < CMP_W; b++) begin
      if (len[b]) lg = LG_W'(b);
    end
  end
  assign lg_cap = (lg > LG_W'(LEVELS - 1)) ? KC_W'(LEVELS - 1) : KC_W'(lg);

  // shared compare unit: first array keeps max, second keeps min
  assign max_pick = (amax_r < rdmax_r) ? rdmax_r : amax_r;
  assign min_pick = (rdmin_r < amin_r) ? rdmin_r : amin_r;

  assign build_rd = (state_r == S_BRD0) || (state_r == S_BRD1);
  assign rd_lvl   = build_rd ? (k_r - KC_W'(1)) : k_r;
  assign rd_k     = rd_lvl[K_W-1:0];
  assign rd_j     = ((state_r == S_BRD0) || (state_r == S_QRD0)) ? j_r[IDX_W-1:0]
                                                                 : a2_r[IDX_W-1:0];

  always_comb begin
    wr_en  = 1'b0;
    wr_k   = '0;
    wr_j   = left_w[IDX_W-1:0];
    wr_max = in_first_value;
    wr_min = in_second_value;
    if (state_r == S_BWR) begin
      wr_en  = 1'b1;
      wr_k   = k_r[K_W-1:0];
      wr_j   = j_r[IDX_W-1:0];
      wr_max = max_pick;
      wr_min = min_pick;
    end else if (accept && (in_op == OP_LOAD) && (left_w < CMP_W'(DEPTH))) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      max_mem[wr_k][wr_j] <= wr_max;
      min_mem[wr_k][wr_j] <= wr_min;
    end
    rdmax_r <= max_mem[rd_k][rd_j];
    rdmin_r <= min_mem[rd_k][rd_j];
  end

  always_comb begin
    state_nxt   = state_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    right_nxt   = right_r;
    a2_nxt      = a2_r;
    emit        = 1'b0;
    emit_max    = '0;
    emit_min    = '0;
    emit_status = ST_ANSWER;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_BUILD: begin
              k_nxt     = KC_W'(1);
              j_nxt     = '0;
              state_nxt = S_BCHK;
            end
            OP_QUERY: begin
              if (bad_range) begin
                emit        = 1'b1;
                emit_status = ST_RANGE_ERR;
              end else begin
                j_nxt     = left_w;
                right_nxt = right_w;
                state_nxt = S_QLOG;
              end
            end
            default: ;  // load is handled by the write port, op 3 is dropped
          endcase
        end
      end
      S_QLOG: begin
        k_nxt     = lg_cap;
        state_nxt = S_QRD0;
      end
      S_QRD0: begin
        a2_nxt    = right_r + CMP_W'(1) - span;
        state_nxt = S_QRD1;
      end
      S_QRD1: state_nxt = S_QOUT;
      S_QOUT: begin
        emit        = 1'b1;
        emit_max    = max_pick;
        emit_min    = min_pick;
        emit_status = ST_ANSWER;
        state_nxt   = S_IDLE;
      end
      S_BCHK: begin
        if ((k_r >= KC_W'(LEVELS)) || (span > n_act)) begin
          emit        = 1'b1;
          emit_status = ST_DONE;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_BRD0;
        end
      end
      S_BRD0: begin
        a2_nxt    = j_r + half;
        state_nxt = S_BRD1;
      end
      S_BRD1: state_nxt = S_BWR;
      S_BWR: begin
        if ((j_r + CMP_W'(1) + span) <= n_act) begin
          j_nxt     = j_r + CMP_W'(1);
          state_nxt = S_BRD0;
        end else begin
          k_nxt     = k_r + KC_W'(1);
          j_nxt     = '0;
          state_nxt = S_BCHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      elem_r      <= ELEM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (cfg_we) begin
        elem_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    right_r <= right_nxt;
    a2_r    <= a2_nxt;
    // first read of a pair is held while the second comes out of the table
    if ((state_r == S_QRD1) || (state_r == S_BRD1)) begin
      amax_r <= rdmax_r;
      amin_r <= rdmin_r;
    end
    if (emit) begin
      out_max_r    <= emit_max;
      out_min_r    <= emit_min;
      out_status_r <= emit_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_range_max = out_max_r;
  assign out_range_min = out_min_r;
  assign out_status    = out_status_r;

  `STRMM_ASSERT_IMP(a_out_when_idle, out_valid, !busy, "result strobe while busy")
  `STRMM_ASSERT_NXT(a_load_silent, accept && (in_op == OP_LOAD), !out_valid && !busy, "load gave a result")
  `STRMM_ASSERT_NXT(a_query_runs, accept && (in_op == OP_QUERY) && !bad_range, busy, "good query did not start")
  `STRMM_ASSERT_IMP(a_err_zero, out_valid && (out_status != ST_ANSWER), (out_range_max == 0) && (out_range_min == 0), "nonzero payload on done or error")
  `STRMM_ASSERT_IMP(a_build_level, state_r == S_BWR, (k_r != 0) && (k_r < KC_W'(LEVELS)), "build writes outside levels")

endmodule
